### rtl/core/vfe_pkg.sv
// Package for the voxel face extractor: face slot, axis and facing codes,
// and the face-set record passed from the scan stage to the face emitter.
// No dependencies.
package vfe_pkg;

    typedef logic [15:0] t_block;
    typedef logic [4:0]  t_coord;

    // Normal axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Facing codes
    localparam logic [2:0] FACING_WEST  = 3'd0;
    localparam logic [2:0] FACING_EAST  = 3'd1;
    localparam logic [2:0] FACING_DOWN  = 3'd2;
    localparam logic [2:0] FACING_UP    = 3'd3;
    localparam logic [2:0] FACING_SOUTH = 3'd4;
    localparam logic [2:0] FACING_NORTH = 3'd5;

    // Face slots of one voxel, in emission order (low side before high side)
    localparam logic [2:0] SLOT_X_LO = 3'd0;
    localparam logic [2:0] SLOT_X_HI = 3'd1;
    localparam logic [2:0] SLOT_Y_LO = 3'd2;
    localparam logic [2:0] SLOT_Y_HI = 3'd3;
    localparam logic [2:0] SLOT_Z_LO = 3'd4;
    localparam logic [2:0] SLOT_Z_HI = 3'd5;

    // All faces caused by one voxel
    typedef struct packed {
        logic [5:0]       mask;      // one bit per face slot
        logic [2:0]       lo_up;     // low-side face points to +axis (neighbor owns it)
        t_block [2:0]     lo_blk;    // owner id of the low-side face, per axis
        t_block           cur_blk;   // id of the voxel itself
        t_coord [2:0]     pos;       // voxel position, x at index 0
        t_coord           edge_pos;  // coordinate of a high boundary face
    } t_face_set;

endpackage

### rtl/core/vfe_ifs.sv
// Request channel interfaces of the voxel face extractor: voxel input and
// face output, each with valid/ready. No dependencies.
interface vfe_voxel_if;
    logic        valid;
    logic        ready;
    logic [15:0] voxel_id;

    modport source (output valid, output voxel_id, input ready);
    modport sink   (input valid, input voxel_id, output ready);
endinterface

interface vfe_face_if;
    logic        valid;
    logic        ready;
    logic [1:0]  face_axis;
    logic [4:0]  face_x;
    logic [4:0]  face_y;
    logic [4:0]  face_z;
    logic [15:0] face_block;
    logic [2:0]  facing;
    logic        run_end;

    modport source (output valid, output face_axis, output face_x, output face_y,
                    output face_z, output face_block, output facing, output run_end,
                    input ready);
    modport sink   (input valid, input face_axis, input face_x, input face_y,
                    input face_z, input face_block, input facing, input run_end,
                    output ready);
endinterface

### rtl/core/vfe_ram.sv
// Generic single-port synchronous RAM, read-first, registered read data.
// No dependencies.
module vfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read old contents, then overwrite
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/vfe_scan.sv
// Scan stage of the voxel face extractor: position counters, neighbor
// memory addressing, and face classification. Depends on vfe_pkg.
module vfe_scan import vfe_pkg::*; #(
    parameter int CHUNK_EDGE = 16,
    parameter int ID_BITS    = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic [15:0]                                i_voxel_id,
    output logic                                       o_ready,
    output logic                                       o_mem_en,
    output logic [$clog2(CHUNK_EDGE*CHUNK_EDGE)-1:0]   o_plane_addr,
    output logic [$clog2(CHUNK_EDGE)-1:0]              o_row_addr,
    output logic [ID_BITS-1:0]                         o_wdata,
    input  logic [ID_BITS-1:0]                         i_plane_rdata,
    input  logic [ID_BITS-1:0]                         i_row_rdata,
    output logic                                       o_set_valid,
    output t_face_set                                  o_set,
    input  logic                                       i_set_ready
);

    localparam int PosW   = $clog2(CHUNK_EDGE);
    localparam int PlaneW = $clog2(CHUNK_EDGE * CHUNK_EDGE);
    localparam logic [PosW-1:0]   PosLast   = PosW'(CHUNK_EDGE - 1);
    localparam logic [PlaneW-1:0] PlaneLast = PlaneW'(CHUNK_EDGE * CHUNK_EDGE - 1);
    localparam t_coord            EdgeCoord = t_coord'(CHUNK_EDGE);

    logic [PosW-1:0]    r_pos_x, r_pos_y, r_pos_z;
    logic [PosW-1:0]    n_pos_x, n_pos_y, n_pos_z;
    logic [PlaneW-1:0]  r_plane_idx, n_plane_idx;
    logic [ID_BITS-1:0] r_prior;
    logic               r_s1_valid;
    logic [ID_BITS-1:0] r_s1_cur, r_s1_nz;
    logic [PosW-1:0]    r_s1_x, r_s1_y, r_s1_z;

    logic [ID_BITS-1:0]            cur;
    logic                          accept;
    logic                          s1_adv;
    logic                          cur_solid;
    logic [2:0][ID_BITS-1:0]       nb_id;
    logic [2:0][PosW-1:0]          coord;
    t_face_set                     set;

    assign cur      = ID_BITS'(i_voxel_id);
    assign s1_adv   = r_s1_valid && ((set.mask == '0) || i_set_ready);
    assign o_ready  = !r_s1_valid || s1_adv;
    assign accept   = i_valid && o_ready;

    // Read the -x and -y neighbors and store the current voxel in one access
    assign o_mem_en     = accept;
    assign o_plane_addr = r_plane_idx;
    assign o_row_addr   = r_pos_z;
    assign o_wdata      = cur;

    // Advance the scan position, z innermost, wrap at chunk end
    always_comb begin
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_pos_z     = r_pos_z + PosW'(1);
        n_plane_idx = (r_plane_idx == PlaneLast) ? '0 : r_plane_idx + PlaneW'(1);
        if (r_pos_z == PosLast) begin
            n_pos_z = '0;
            n_pos_y = r_pos_y + PosW'(1);
            if (r_pos_y == PosLast) begin
                n_pos_y = '0;
                n_pos_x = (r_pos_x == PosLast) ? '0 : r_pos_x + PosW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_plane_idx <= '0;
            r_prior     <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_pos_z     <= n_pos_z;
                r_plane_idx <= n_plane_idx;
                r_prior     <= cur;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Hold the request for the cycle in which neighbor data returns
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur <= cur;
            r_s1_nz  <= r_prior;
            r_s1_x   <= r_pos_x;
            r_s1_y   <= r_pos_y;
            r_s1_z   <= r_pos_z;
        end
    end

    // Classify the low-side and boundary faces on each axis
    assign nb_id     = {r_s1_nz, i_row_rdata, i_plane_rdata};
    assign coord     = {r_s1_z, r_s1_y, r_s1_x};
    assign cur_solid = (r_s1_cur != '0);

    always_comb begin
        set          = '0;
        set.cur_blk  = t_block'(r_s1_cur);
        set.edge_pos = EdgeCoord;
        for (int a = 0; a < 3; a++) begin
            set.pos[a]        = t_coord'(coord[a]);
            set.lo_up[a]      = !cur_solid;
            set.lo_blk[a]     = cur_solid ? t_block'(r_s1_cur) : t_block'(nb_id[a]);
            set.mask[2*a]     = (coord[a] == '0) ? cur_solid
                                                 : (cur_solid != (nb_id[a] != '0));
            set.mask[2*a + 1] = (coord[a] == PosLast) && cur_solid;
        end
    end

    // Drop voxels that cause no face
    assign o_set_valid = r_s1_valid && (set.mask != '0);
    assign o_set       = set;

endmodule

### rtl/core/vfe_emit.sv
// Face emitter of the voxel face extractor: holds one voxel's face set and
// sends its faces one request per cycle in slot order while o_face is ready.
// Depends on vfe_pkg and vfe_face_if.
module vfe_emit import vfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_set_valid,
    input  t_face_set   i_set,
    output logic        o_set_ready,
    vfe_face_if.source  o_face
);

    logic [5:0] r_mask, n_mask;
    t_face_set  r_set;

    logic [2:0] slot;
    logic [5:0] rest;
    logic       take;
    logic       load;

    // Pick the lowest pending slot
    always_comb begin
        slot = SLOT_X_LO;
        for (int i = 5; i >= 0; i--) begin
            if (r_mask[i]) begin
                slot = 3'(i);
            end
        end
    end

    assign rest        = r_mask & (r_mask - 6'd1);
    assign take        = o_face.valid && o_face.ready;
    assign o_set_ready = (r_mask == '0) || (take && (rest == '0));
    assign load        = o_set_ready && i_set_valid;

    always_comb begin
        n_mask = r_mask;
        if (take) begin
            n_mask = rest;
        end
        if (load) begin
            n_mask = i_set.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_set <= i_set;
        end
    end

    // Build the face request for the current slot
    always_comb begin
        o_face.valid      = (r_mask != '0);
        o_face.run_end    = (rest == '0);
        o_face.face_x     = r_set.pos[0];
        o_face.face_y     = r_set.pos[1];
        o_face.face_z     = r_set.pos[2];
        o_face.face_block = r_set.cur_blk;
        case (slot)
            SLOT_X_LO: begin
                o_face.face_axis  = AXIS_X;
                o_face.facing     = r_set.lo_up[0] ? FACING_EAST : FACING_WEST;
                o_face.face_block = r_set.lo_blk[0];
            end
            SLOT_X_HI: begin
                o_face.face_axis  = AXIS_X;
                o_face.facing     = FACING_EAST;
                o_face.face_x     = r_set.edge_pos;
            end
            SLOT_Y_LO: begin
                o_face.face_axis  = AXIS_Y;
                o_face.facing     = r_set.lo_up[1] ? FACING_UP : FACING_DOWN;
                o_face.face_block = r_set.lo_blk[1];
            end
            SLOT_Y_HI: begin
                o_face.face_axis  = AXIS_Y;
                o_face.facing     = FACING_UP;
                o_face.face_y     = r_set.edge_pos;
            end
            SLOT_Z_LO: begin
                o_face.face_axis  = AXIS_Z;
                o_face.facing     = r_set.lo_up[2] ? FACING_NORTH : FACING_SOUTH;
                o_face.face_block = r_set.lo_blk[2];
            end
            SLOT_Z_HI: begin
                o_face.face_axis  = AXIS_Z;
                o_face.facing     = FACING_NORTH;
                o_face.face_z     = r_set.edge_pos;
            end
            default: begin
                o_face.face_axis  = AXIS_X;
                o_face.facing     = FACING_WEST;
            end
        endcase
    end

endmodule

### rtl/core/voxel_face_extractor_unit.sv
// Voxel face extractor, top level: scan stage, neighbor memories and face
// emitter. Depends on vfe_pkg, vfe_ifs, vfe_ram, vfe_scan and vfe_emit.
//
// Usage:
//   i_voxel takes one block id per request, a chunk of CHUNK_EDGE^3 voxels
//   in x, y, z order with z innermost; id 0 is empty. After the last voxel
//   of a chunk the position wraps and the next request starts a new chunk.
//   o_face carries one visible face per request: axis, lattice position,
//   owning block id, facing side, and run_end on the last face of a voxel.
//   A voxel with no visible face produces no request.
// Timing:
//   The first face of a voxel is offered once the voxel has passed the scan
//   stage register and been loaded into the emitter, which holds it until the
//   last of its faces (up to six) is taken. Runs of voxels with at most one
//   face stream at one voxel per cycle while o_face is ready. The emitter
//   drains one voxel while the next is looked up in the plane and row memories.
// Reset and stall:
//   Reset returns the scan position to the chunk origin and drops any
//   pending faces; memory contents are not cleared and need not be. When
//   o_face is stalled, faces hold and i_voxel drops ready once the scan
//   stage is also full.
module voxel_face_extractor_unit import vfe_pkg::*; #(
    parameter int CHUNK_EDGE = 16,
    parameter int ID_BITS    = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vfe_voxel_if.sink    i_voxel,
    vfe_face_if.source   o_face
);

    localparam int PosW   = $clog2(CHUNK_EDGE);
    localparam int PlaneW = $clog2(CHUNK_EDGE * CHUNK_EDGE);

    logic               mem_en;
    logic [PlaneW-1:0]  plane_addr;
    logic [PosW-1:0]    row_addr;
    logic [ID_BITS-1:0] wdata;
    logic [ID_BITS-1:0] plane_rdata;
    logic [ID_BITS-1:0] row_rdata;
    logic               set_valid;
    logic               set_ready;
    t_face_set          set;

    // Previous x plane, indexed by y*CHUNK_EDGE+z
    vfe_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CHUNK_EDGE * CHUNK_EDGE)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_en),
        .i_addr  (plane_addr),
        .i_wdata (wdata),
        .o_rdata (plane_rdata)
    );

    // Previous y row, indexed by z
    vfe_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CHUNK_EDGE)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_en),
        .i_addr  (row_addr),
        .i_wdata (wdata),
        .o_rdata (row_rdata)
    );

    vfe_scan #(
        .CHUNK_EDGE (CHUNK_EDGE),
        .ID_BITS    (ID_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_voxel.valid),
        .i_voxel_id    (i_voxel.voxel_id),
        .o_ready       (i_voxel.ready),
        .o_mem_en      (mem_en),
        .o_plane_addr  (plane_addr),
        .o_row_addr    (row_addr),
        .o_wdata       (wdata),
        .i_plane_rdata (plane_rdata),
        .i_row_rdata   (row_rdata),
        .o_set_valid   (set_valid),
        .o_set         (set),
        .i_set_ready   (set_ready)
    );

    vfe_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set_valid (set_valid),
        .i_set       (set),
        .o_set_ready (set_ready),
        .o_face      (o_face)
    );

endmodule
